// ===== hdl/ir_assembly_tokenizer_macros.svh =====
// Assertion macros shared by the tokenizer checker.
`ifndef IR_ASSEMBLY_TOKENIZER_MACROS_SVH
`define IR_ASSEMBLY_TOKENIZER_MACROS_SVH

// Same-cycle implication, with a reset that disables the check.
`define ITK_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, with a reset that disables the check.
`define ITK_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/itk_pkg.sv =====
// Shared types and constants of the assembly tokenizer.
package itk_pkg;

   // Widths of the transaction fields.
   localparam int unsigned KIND_W = 5;
   localparam int unsigned POS_W  = 32;
   localparam int unsigned LEN_W  = 16;
   localparam int unsigned CHAR_W = 8;

   // Token kinds.
   localparam logic [KIND_W-1:0] TK_IDENT   = 5'd0;
   localparam logic [KIND_W-1:0] TK_MODULE  = 5'd1;
   localparam logic [KIND_W-1:0] TK_FUNC    = 5'd2;
   localparam logic [KIND_W-1:0] TK_MEMREF  = 5'd3;
   localparam logic [KIND_W-1:0] TK_TENSOR  = 5'd4;
   localparam logic [KIND_W-1:0] TK_INT     = 5'd5;
   localparam logic [KIND_W-1:0] TK_FLOAT   = 5'd6;
   localparam logic [KIND_W-1:0] TK_LPAREN  = 5'd7;
   localparam logic [KIND_W-1:0] TK_RPAREN  = 5'd8;
   localparam logic [KIND_W-1:0] TK_LBRACE  = 5'd9;
   localparam logic [KIND_W-1:0] TK_RBRACE  = 5'd10;
   localparam logic [KIND_W-1:0] TK_COMMA   = 5'd11;
   localparam logic [KIND_W-1:0] TK_COLON   = 5'd12;
   localparam logic [KIND_W-1:0] TK_LESS    = 5'd13;
   localparam logic [KIND_W-1:0] TK_GREATER = 5'd14;
   localparam logic [KIND_W-1:0] TK_EQUAL   = 5'd15;
   localparam logic [KIND_W-1:0] TK_AT      = 5'd16;
   localparam logic [KIND_W-1:0] TK_PLUS    = 5'd17;
   localparam logic [KIND_W-1:0] TK_MINUS   = 5'd18;
   localparam logic [KIND_W-1:0] TK_ARROW   = 5'd19;
   localparam logic [KIND_W-1:0] TK_STAR    = 5'd20;
   localparam logic [KIND_W-1:0] TK_UNKNOWN = 5'd21;
   localparam logic [KIND_W-1:0] TK_EOF     = 5'd22;

   // Keyword texts, last character in the low byte.
   localparam logic [47:0] KW_MODULE = 48'h6D6F64756C65;
   localparam logic [31:0] KW_FUNC   = 32'h66756E63;
   localparam logic [47:0] KW_MEMREF = 48'h6D656D726566;
   localparam logic [47:0] KW_TENSOR = 48'h74656E736F72;

   // Depth of the token queue between scanner and output stage.
   localparam int unsigned TOKQ_DEPTH = 4;

   // One finished token as it leaves the block.
   typedef struct packed {
      logic [KIND_W-1:0] token_kind;
      logic [POS_W-1:0]  token_line;
      logic [POS_W-1:0]  token_column;
      logic [POS_W-1:0]  token_offset;
      logic [LEN_W-1:0]  token_length;
      logic [CHAR_W-1:0] token_char;
      logic              last_of_run;
   } token_type;

   // Up to two tokens written by the scanner in one cycle, in order.
   typedef struct packed {
      logic      a_valid;
      token_type a;
      logic      b_valid;
      token_type b;
   } push_type;

   // Head of the token queue as seen by the output stage.
   typedef struct packed {
      logic      not_empty;
      token_type head;
   } head_type;

endpackage

// ===== hdl/itk_req_if.sv =====
// Input channel: one source byte or an end-of-input marker per transaction.
interface itk_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] char_byte;

   modport source (output valid, output kind, output char_byte, input ready);
   modport sink   (input valid, input kind, input char_byte, output ready);
endinterface

// ===== hdl/itk_rsp_if.sv =====
// Result channel: one token per transaction.
interface itk_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  token_kind;
   logic [31:0] token_line;
   logic [31:0] token_column;
   logic [31:0] token_offset;
   logic [15:0] token_length;
   logic [7:0]  token_char;
   logic        last_of_run;

   modport source (output valid, output token_kind, output token_line, output token_column,
                   output token_offset, output token_length, output token_char,
                   output last_of_run, input ready);
   modport sink   (input valid, input token_kind, input token_line, input token_column,
                   input token_offset, input token_length, input token_char,
                   input last_of_run, output ready);
endinterface

// ===== hdl/itk_front.sv =====
// Scanner front end: classifies each byte and forms up to two tokens per transaction.
module itk_front #(
   parameter int unsigned POSITION_WIDTH = 32,
   parameter int unsigned LENGTH_WIDTH   = 16
) (
   input  logic             clock,
   input  logic             reset,
   itk_req_if.sink          req_bus,
   input  logic             space_ok,
   output itk_pkg::push_type push
);

   typedef enum logic [4:0] {
      MODE_IDLE    = 5'b00001,
      MODE_IDENT   = 5'b00010,
      MODE_NUMBER  = 5'b00100,
      MODE_MINUS   = 5'b01000,
      MODE_COMMENT = 5'b10000
   } mode_type;

   typedef logic [POSITION_WIDTH-1:0] pos_type;
   typedef logic [LENGTH_WIDTH-1:0]   len_type;

   mode_type   mode_ff, mode_in;
   pos_type    line_ff, line_in;
   pos_type    col_ff, col_in;
   pos_type    off_ff, off_in;
   pos_type    sline_ff, sline_in;
   pos_type    scol_ff, scol_in;
   pos_type    soff_ff, soff_in;
   len_type    plen_ff, plen_in;
   logic       dot_ff, dot_in;
   logic [47:0] win_ff, win_in;
   logic [7:0] first_ff, first_in;

   logic       fire;
   logic [7:0] c;
   logic       is_digit, is_alpha, is_space, ident_char;
   logic       consumed;
   logic [itk_pkg::KIND_W-1:0] flush_kind;
   itk_pkg::token_type tok_a, tok_b;
   logic       a_v, b_v;

   function automatic pos_type pos_inc(input pos_type v);
      pos_inc = (&v) ? v : v + 1'b1;
   endfunction

   function automatic logic [itk_pkg::KIND_W-1:0] punct_kind(input logic [7:0] ch);
      case (ch)
         "(":     punct_kind = itk_pkg::TK_LPAREN;
         ")":     punct_kind = itk_pkg::TK_RPAREN;
         "{":     punct_kind = itk_pkg::TK_LBRACE;
         "}":     punct_kind = itk_pkg::TK_RBRACE;
         ",":     punct_kind = itk_pkg::TK_COMMA;
         ":":     punct_kind = itk_pkg::TK_COLON;
         "<":     punct_kind = itk_pkg::TK_LESS;
         ">":     punct_kind = itk_pkg::TK_GREATER;
         "=":     punct_kind = itk_pkg::TK_EQUAL;
         "@":     punct_kind = itk_pkg::TK_AT;
         "+":     punct_kind = itk_pkg::TK_PLUS;
         "*":     punct_kind = itk_pkg::TK_STAR;
         default: punct_kind = itk_pkg::TK_UNKNOWN;
      endcase
   endfunction

   // Handshake and character classes.
   assign req_bus.ready = space_ok;
   assign fire          = req_bus.valid && space_ok;
   assign c             = req_bus.char_byte;
   assign is_digit      = (c >= "0") && (c <= "9");
   assign is_alpha      = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   assign is_space      = (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
   assign ident_char    = is_alpha || is_digit || (c == "_") || (c == ".");

   // Kind of the pending token, should it be closed now.
   always_comb begin
      flush_kind = itk_pkg::TK_MINUS;
      unique case (mode_ff) inside
         MODE_IDENT: begin
            flush_kind = itk_pkg::TK_IDENT;
            if (plen_ff == LENGTH_WIDTH'(6)) begin
               if (win_ff == itk_pkg::KW_MODULE)      flush_kind = itk_pkg::TK_MODULE;
               else if (win_ff == itk_pkg::KW_MEMREF) flush_kind = itk_pkg::TK_MEMREF;
               else if (win_ff == itk_pkg::KW_TENSOR) flush_kind = itk_pkg::TK_TENSOR;
            end else if (plen_ff == LENGTH_WIDTH'(4) && win_ff[31:0] == itk_pkg::KW_FUNC) begin
               flush_kind = itk_pkg::TK_FUNC;
            end
         end
         MODE_NUMBER: flush_kind = dot_ff ? itk_pkg::TK_FLOAT : itk_pkg::TK_INT;
         MODE_MINUS:  flush_kind = itk_pkg::TK_MINUS;
         MODE_IDLE, MODE_COMMENT: flush_kind = itk_pkg::TK_MINUS;
         default:     flush_kind = itk_pkg::TK_MINUS;
      endcase
   end

   // Next scanner state and the tokens this transaction produces.
   always_comb begin
      mode_in  = mode_ff;
      line_in  = line_ff;
      col_in   = col_ff;
      off_in   = off_ff;
      sline_in = sline_ff;
      scol_in  = scol_ff;
      soff_in  = soff_ff;
      plen_in  = plen_ff;
      dot_in   = dot_ff;
      win_in   = win_ff;
      first_in = first_ff;
      consumed = 1'b0;
      a_v      = 1'b0;
      b_v      = 1'b0;

      tok_a.token_kind   = flush_kind;
      tok_a.token_line   = itk_pkg::POS_W'(sline_ff);
      tok_a.token_column = itk_pkg::POS_W'(scol_ff);
      tok_a.token_offset = itk_pkg::POS_W'(soff_ff);
      tok_a.token_length = itk_pkg::LEN_W'(plen_ff);
      tok_a.token_char   = first_ff;
      tok_a.last_of_run  = 1'b0;

      tok_b.token_kind   = punct_kind(c);
      tok_b.token_line   = itk_pkg::POS_W'(line_ff);
      tok_b.token_column = itk_pkg::POS_W'(col_ff);
      tok_b.token_offset = itk_pkg::POS_W'(off_ff);
      tok_b.token_length = itk_pkg::LEN_W'(1);
      tok_b.token_char   = c;
      tok_b.last_of_run  = 1'b1;

      if (req_bus.kind) begin
         // End of input closes any pending token and reports the end position.
         a_v                = (mode_ff == MODE_IDENT) || (mode_ff == MODE_NUMBER) ||
                              (mode_ff == MODE_MINUS);
         b_v                = 1'b1;
         mode_in            = MODE_IDLE;
         tok_b.token_kind   = itk_pkg::TK_EOF;
         tok_b.token_length = '0;
         tok_b.token_char   = '0;
      end else begin
         // Continue the pending token where the byte allows it.
         unique case (mode_ff) inside
            MODE_IDENT, MODE_NUMBER: begin
               if ((mode_ff == MODE_IDENT) ? ident_char : (is_digit || c == ".")) begin
                  consumed = 1'b1;
                  plen_in  = (&plen_ff) ? plen_ff : plen_ff + 1'b1;
                  win_in   = {win_ff[39:0], c};
                  dot_in   = dot_ff || (c == ".");
                  col_in   = pos_inc(col_ff);
                  off_in   = off_ff + 1'b1;
               end else begin
                  a_v = 1'b1;
               end
            end
            MODE_MINUS: begin
               if (c == ">") begin
                  consumed           = 1'b1;
                  mode_in            = MODE_IDLE;
                  col_in             = pos_inc(col_ff);
                  off_in             = off_ff + 1'b1;
                  b_v                = 1'b1;
                  tok_b.token_kind   = itk_pkg::TK_ARROW;
                  tok_b.token_line   = itk_pkg::POS_W'(sline_ff);
                  tok_b.token_column = itk_pkg::POS_W'(scol_ff);
                  tok_b.token_offset = itk_pkg::POS_W'(soff_ff);
                  tok_b.token_length = itk_pkg::LEN_W'(2);
                  tok_b.token_char   = "-";
               end else begin
                  a_v = 1'b1;
               end
            end
            MODE_COMMENT: begin
               if (c != "\n") begin
                  consumed = 1'b1;
                  col_in   = pos_inc(col_ff);
                  off_in   = off_ff + 1'b1;
               end
            end
            MODE_IDLE: consumed = 1'b0;
            default:   consumed = 1'b0;
         endcase

         // A byte not taken by the pending token starts afresh.
         if (!consumed) begin
            mode_in = MODE_IDLE;
            if (c == "\n") begin
               line_in = pos_inc(line_ff);
               col_in  = POSITION_WIDTH'(1);
               off_in  = off_ff + 1'b1;
            end else if (is_space) begin
               col_in = pos_inc(col_ff);
               off_in = off_ff + 1'b1;
            end else if (c == ";" || c == "#") begin
               mode_in = MODE_COMMENT;
               col_in  = pos_inc(col_ff);
               off_in  = off_ff + 1'b1;
            end else if (is_alpha || is_digit || c == "_" || c == "-") begin
               if (is_digit)    mode_in = MODE_NUMBER;
               else if (c == "-") mode_in = MODE_MINUS;
               else             mode_in = MODE_IDENT;
               sline_in = line_ff;
               scol_in  = col_ff;
               soff_in  = off_ff;
               plen_in  = LENGTH_WIDTH'(1);
               dot_in   = 1'b0;
               win_in   = {40'd0, c};
               first_in = c;
               col_in   = pos_inc(col_ff);
               off_in   = off_ff + 1'b1;
            end else begin
               b_v    = 1'b1;
               col_in = pos_inc(col_ff);
               off_in = off_ff + 1'b1;
            end
         end
      end

      tok_a.last_of_run = !b_v;
   end

   assign push.a_valid = fire && a_v;
   assign push.a       = tok_a;
   assign push.b_valid = fire && b_v;
   assign push.b       = tok_b;

   // Scanner state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         line_ff  <= POSITION_WIDTH'(1);
         col_ff   <= POSITION_WIDTH'(1);
         off_ff   <= '0;
         sline_ff <= '0;
         scol_ff  <= '0;
         soff_ff  <= '0;
         plen_ff  <= '0;
         dot_ff   <= 1'b0;
         win_ff   <= '0;
         first_ff <= '0;
      end else if (fire) begin
         mode_ff  <= mode_in;
         line_ff  <= line_in;
         col_ff   <= col_in;
         off_ff   <= off_in;
         sline_ff <= sline_in;
         scol_ff  <= scol_in;
         soff_ff  <= soff_in;
         plen_ff  <= plen_in;
         dot_ff   <= dot_in;
         win_ff   <= win_in;
         first_ff <= first_in;
      end
   end

endmodule

// ===== hdl/itk_queue.sv =====
// Token queue: takes up to two tokens per cycle from the scanner, gives one per cycle while the output stage pops.
module itk_queue (
   input  logic              clock,
   input  logic              reset,
   input  itk_pkg::push_type push,
   input  logic              pop,
   output itk_pkg::head_type head,
   output logic              space_ok
);

   localparam int unsigned DEPTH = itk_pkg::TOKQ_DEPTH;
   localparam int unsigned PW    = $clog2(DEPTH);
   localparam int unsigned CW    = $clog2(DEPTH + 1);

   itk_pkg::token_type   mem_ff [DEPTH];
   logic [PW-1:0]        wr_ff, wr_in;
   logic [PW-1:0]        rd_ff, rd_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [1:0]           n_push;
   itk_pkg::token_type   first_tok;
   logic [PW-1:0]        wr_next;

   // Compact the two slots so the earlier token is written first.
   assign n_push    = {1'b0, push.a_valid} + {1'b0, push.b_valid};
   assign first_tok = push.a_valid ? push.a : push.b;
   assign wr_next   = wr_ff + 1'b1;

   assign wr_in    = wr_ff + PW'(n_push);
   assign rd_in    = rd_ff + PW'(pop);
   assign count_in = count_ff + CW'(n_push) - CW'(pop);

   // Room for a full two-token transaction is required before accepting.
   assign space_ok       = count_ff <= CW'(DEPTH - 2);
   assign head.not_empty = count_ff != '0;
   assign head.head      = mem_ff[rd_ff];

   // Storage is written without reset.
   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         mem_ff[wr_ff] <= first_tok;
      end
      if (n_push == 2'd2) begin
         mem_ff[wr_next] <= push.b;
      end
   end

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== hdl/itk_out.sv =====
// Output stage: moves the queue head into the result register and drives the channel.
module itk_out (
   input  logic              clock,
   input  logic              reset,
   input  itk_pkg::head_type head,
   output logic              pop,
   itk_rsp_if.source         rsp_bus
);

   logic               valid_ff, valid_in;
   itk_pkg::token_type tok_ff;

   // Load a new token when the register is empty or its token is being taken.
   assign pop      = head.not_empty && (!valid_ff || rsp_bus.ready);
   assign valid_in = pop || (valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         tok_ff <= head.head;
      end
   end

   assign rsp_bus.valid        = valid_ff;
   assign rsp_bus.token_kind   = tok_ff.token_kind;
   assign rsp_bus.token_line   = tok_ff.token_line;
   assign rsp_bus.token_column = tok_ff.token_column;
   assign rsp_bus.token_offset = tok_ff.token_offset;
   assign rsp_bus.token_length = tok_ff.token_length;
   assign rsp_bus.token_char   = tok_ff.token_char;
   assign rsp_bus.last_of_run  = tok_ff.last_of_run;

endmodule

// ===== hdl/ir_assembly_tokenizer.sv =====
// A token completed by an accepted byte is queued, then moved to the result register when free.
// Throughput: one byte per cycle while two queue entries are free; the output stage gives one
// token per cycle when taken; a second token from one byte waits in a 4-entry queue.
// Input is held off while fewer than two queue entries are free.
// Reset (synchronous): scanner idle, line 1, column 1, offset 0, queue and output emptied.
module ir_assembly_tokenizer #(
   parameter int unsigned POSITION_WIDTH = 32,
   parameter int unsigned LENGTH_WIDTH   = 16
) (
   input  logic      clock,
   input  logic      reset,
   itk_req_if.sink   req_bus,
   itk_rsp_if.source rsp_bus
);

   itk_pkg::push_type push;
   itk_pkg::head_type head;
   logic              pop;
   logic              space_ok;

   // Scanner.
   itk_front #(
      .POSITION_WIDTH (POSITION_WIDTH),
      .LENGTH_WIDTH   (LENGTH_WIDTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .space_ok (space_ok),
      .push     (push)
   );

   // Token queue.
   itk_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .pop      (pop),
      .head     (head),
      .space_ok (space_ok)
   );

   // Result register.
   itk_out u_out (
      .clock   (clock),
      .reset   (reset),
      .head    (head),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

endmodule

// ===== hdl/itk_checker.sv =====
// Port-level checks of the tokenizer and their attachment to the top level.
`include "ir_assembly_tokenizer_macros.svh"

module itk_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [4:0]  rsp_token_kind,
   input logic [15:0] rsp_token_length,
   input logic [7:0]  rsp_token_char,
   input logic        rsp_last_of_run
);

   // A stalled token keeps its place.
   `ITK_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_token_kind) && $stable(rsp_token_length), "stalled token changed")

   // The end token closes its run and has no text.
   `ITK_ASSERT_IMP(a_eof_shape, clock, reset, rsp_valid && rsp_token_kind == itk_pkg::TK_EOF, rsp_last_of_run && rsp_token_length == 16'd0 && rsp_token_char == 8'd0, "malformed end token")

   // An arrow is always two bytes starting with a minus, alone in its run.
   `ITK_ASSERT_IMP(a_arrow_shape, clock, reset, rsp_valid && rsp_token_kind == itk_pkg::TK_ARROW, rsp_last_of_run && rsp_token_length == 16'd2 && rsp_token_char == "-", "malformed arrow token")

   // Nothing is offered in the cycle after reset.
   `ITK_ASSERT_IMP(a_reset_quiet, clock, 1'b0, $past(reset), !rsp_valid, "result valid after reset")

endmodule

bind ir_assembly_tokenizer itk_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_token_kind   (rsp_bus.token_kind),
   .rsp_token_length (rsp_bus.token_length),
   .rsp_token_char   (rsp_bus.token_char),
   .rsp_last_of_run  (rsp_bus.last_of_run)
);
